// File: hw/rtl/etpq_pkg.sv
`default_nettype none
package etpq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ENTITY_BITS = 8;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned ENTITY_W    = 8;
  localparam int unsigned DELAY_W     = 10;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_POP,
    MODE_INSERT,
    MODE_POP_INSERT
  } mode_e;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [ENTITY_BITS-1:0] entity;
  } slot_t;

  typedef struct packed {
    mode_e                  mode;
    logic [KEY_W-1:0]       key;
    logic [ENTITY_BITS-1:0] entity;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/etpq_cell.sv
`default_nettype none
module etpq_cell (
  input  logic                clk_i,
  input  etpq_pkg::cell_ctrl_t ctrl_i,
  input  etpq_pkg::slot_t     prev_slot_i,
  input  etpq_pkg::slot_t     next_slot_i,
  input  logic                own_occ_i,
  input  logic                next_occ_i,
  input  logic                prev_gt_i,
  output etpq_pkg::slot_t     slot_o,
  output logic                gt_o
);
  import etpq_pkg::*;

  slot_t slot_q;
  slot_t slot_d;
  slot_t base;
  slot_t prev_base;
  logic  base_occ;

  // A combined pop and insert sees the queue as if the head were already gone.
  always_comb begin
    if (ctrl_i.mode == MODE_POP_INSERT) begin
      base      = next_slot_i;
      prev_base = slot_q;
      base_occ  = next_occ_i;
    end else begin
      base      = slot_q;
      prev_base = prev_slot_i;
      base_occ  = own_occ_i;
    end
    gt_o = !base_occ || (base.key > ctrl_i.key);

    unique case (ctrl_i.mode)
      MODE_HOLD: begin
        slot_d = slot_q;
      end
      MODE_POP: begin
        slot_d = next_slot_i;
      end
      MODE_INSERT, MODE_POP_INSERT: begin
        if (!gt_o) begin
          slot_d = base;
        end else if (!prev_gt_i) begin
          slot_d.key    = ctrl_i.key;
          slot_d.entity = ctrl_i.entity;
        end else begin
          slot_d = prev_base;
        end
      end
      default: begin
        slot_d = slot_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

// File: hw/rtl/event_time_priority_queue.sv
// The result word for an item appears in the cycle after the item is accepted.
// Throughput: one item per cycle unless stalled; every operation finishes in a
// single pass through the row of cells, each cell comparing the new key with its
// own entry in parallel. Reset empties the queue and clears the turn counter; no
// clearing pass is needed, so the block accepts items as soon as reset is released.
`default_nettype none
module event_time_priority_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        operation_i,
  input  logic [etpq_pkg::ENTITY_W-1:0]     entity_id_i,
  input  logic [etpq_pkg::KEY_W-1:0]        due_time_i,
  input  logic [etpq_pkg::DELAY_W-1:0]      reschedule_delay_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              fired_valid_o,
  output logic [etpq_pkg::ENTITY_W-1:0]     fired_entity_o,
  output logic [etpq_pkg::KEY_W-1:0]        fired_time_o,
  output logic                              head_valid_o,
  output logic [etpq_pkg::ENTITY_W-1:0]     head_entity_o,
  output logic [etpq_pkg::KEY_W-1:0]        head_time_o,
  output logic [etpq_pkg::CNT_W-1:0]        entry_count_o,
  output logic                              overflow_o,
  output logic [etpq_pkg::KEY_W-1:0]        turn_now_o
);
  import etpq_pkg::*;

  localparam logic [KEY_W-1:0] KeyMax = '1;

  slot_t      slots [QUEUE_DEPTH];
  logic       gts   [QUEUE_DEPTH];
  logic       occ   [QUEUE_DEPTH];
  cell_ctrl_t ctrl;

  logic                   out_valid_q;
  logic                   fired_valid_q, fired_valid_d;
  logic [ENTITY_BITS-1:0] fired_entity_q, fired_entity_d;
  logic [KEY_W-1:0]       fired_time_q, fired_time_d;
  logic                   overflow_q, overflow_d;
  logic [KEY_W-1:0]       turn_q, turn_d;
  logic [CNT_W-1:0]       count_q, count_d;

  logic                   accept;
  logic                   head_occ;
  logic [KEY_W-1:0]       turn_inc;
  logic [KEY_W:0]         resched_sum;
  logic [KEY_W-1:0]       resched_key;
  op_e                    op;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign head_occ   = (count_q != '0);
  assign op         = op_e'(operation_i);

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      slot_t prev_slot;
      slot_t next_slot;
      logic  next_occ;
      logic  prev_gt;

      assign occ[gi] = (CNT_W'(gi) < count_q);

      if (gi == 0) begin : g_first
        assign prev_slot = '0;
        assign prev_gt   = 1'b0;
      end else begin : g_mid
        assign prev_slot = slots[gi-1];
        assign prev_gt   = gts[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign next_slot = '0;
        assign next_occ  = 1'b0;
      end else begin : g_inner
        assign next_slot = slots[gi+1];
        assign next_occ  = occ[gi+1];
      end

      etpq_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .prev_slot_i (prev_slot),
        .next_slot_i (next_slot),
        .own_occ_i   (occ[gi]),
        .next_occ_i  (next_occ),
        .prev_gt_i   (prev_gt),
        .slot_o      (slots[gi]),
        .gt_o        (gts[gi])
      );
    end
  endgenerate

  assign turn_inc    = (turn_q == KeyMax) ? turn_q : turn_q + KEY_W'(1);
  assign resched_sum = {1'b0, slots[0].key} + (KEY_W + 1)'(reschedule_delay_i);
  assign resched_key = resched_sum[KEY_W] ? KeyMax : resched_sum[KEY_W-1:0];

  always_comb begin
    ctrl.mode      = MODE_HOLD;
    ctrl.key       = due_time_i;
    ctrl.entity    = entity_id_i[ENTITY_BITS-1:0];
    fired_valid_d  = 1'b0;
    fired_entity_d = '0;
    fired_time_d   = '0;
    overflow_d     = 1'b0;
    turn_d         = turn_q;
    count_d        = count_q;

    unique case (op)
      OP_INSERT: begin
        if (count_q == CNT_W'(QUEUE_DEPTH)) begin
          overflow_d = 1'b1;
        end else begin
          ctrl.mode = MODE_INSERT;
          count_d   = count_q + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (head_occ) begin
          ctrl.mode      = MODE_POP;
          fired_valid_d  = 1'b1;
          fired_entity_d = slots[0].entity;
          fired_time_d   = slots[0].key;
          count_d        = count_q - CNT_W'(1);
        end
      end
      OP_TICK: begin
        turn_d = turn_inc;
        if (head_occ && (turn_inc >= slots[0].key)) begin
          ctrl.mode      = MODE_POP_INSERT;
          ctrl.key       = resched_key;
          ctrl.entity    = slots[0].entity;
          fired_valid_d  = 1'b1;
          fired_entity_d = slots[0].entity;
          fired_time_d   = slots[0].key;
        end
      end
      OP_NONE: begin
        ctrl.mode = MODE_HOLD;
      end
      default: begin
        ctrl.mode = MODE_HOLD;
      end
    endcase

    if (!accept) begin
      ctrl.mode = MODE_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      turn_q      <= '0;
      count_q     <= '0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        turn_q      <= turn_d;
        count_q     <= count_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fired_valid_q  <= fired_valid_d;
      fired_entity_q <= fired_entity_d;
      fired_time_q   <= fired_time_d;
      overflow_q     <= overflow_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fired_valid_o  = fired_valid_q;
  assign fired_entity_o = ENTITY_W'(fired_entity_q);
  assign fired_time_o   = fired_time_q;
  assign head_valid_o   = head_occ;
  assign head_entity_o  = head_occ ? ENTITY_W'(slots[0].entity) : '0;
  assign head_time_o    = head_occ ? slots[0].key : '0;
  assign entry_count_o  = count_q;
  assign overflow_o     = overflow_q;
  assign turn_now_o     = turn_q;

endmodule
`default_nettype wire
